@@ rtl/core/pcsh_pkg.sv @@
// Shared types and constants for the program-counter sampling histogram.
// Used by the front end, the back end and the top level; no dependencies.
package pcsh_pkg;

  // Request operation codes on the input channel
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PC_SHIFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_LIMIT = 3'd4;

  typedef struct packed {
    logic        enable;
    logic [31:0] text_low;
    logic [31:0] text_high;
    logic [4:0]  pc_shift;
    logic [12:0] bin_limit;
  } cfg_t;

  // Command handed from the front end to the back end through the queue
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_INC,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  localparam int unsigned CMD_W = 2;

endpackage

@@ rtl/core/pcsh_queue.sv @@
// Small first-in first-out queue between the front end and the back end.
// Generic storage only; no package dependency. DEPTH is a power of two.
module pcsh_queue #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      cnt_r;

  assign full      = (cnt_r == (PW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/pcsh_front.sv @@
// Front end: accepts requests, checks the address window, forms the bin
// number and pushes one command per request. Depends on pcsh_pkg.
module pcsh_front #(
  parameter int unsigned NUM_BINS = 4096
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  pcsh_pkg::cfg_t                             cfg,
  input  logic                                       sweeping,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [1:0]                                 in_operation,
  input  logic [31:0]                                in_pc,
  input  logic                                       in_supervisor,
  input  logic [11:0]                                in_bin_index,
  output logic                                       q_push,
  output logic [pcsh_pkg::CMD_W+$clog2(NUM_BINS)-1:0] q_data,
  input  logic                                       q_full
);
  import pcsh_pkg::*;

  localparam int unsigned ABITS = $clog2(NUM_BINS);

  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic        s1_in_range_r;
  logic [31:0] s1_offset_r;
  logic [11:0] s1_idx_r;

  logic        accept;
  logic        in_range;
  logic [31:0] bin;
  logic [31:0] idx_ext;
  logic [31:0] lim_eff;
  cmd_kind_t   kind;
  logic [ABITS-1:0] addr;

  // Window check and offset in the accept cycle; shift and limit check next
  assign in_range = cfg.enable && in_supervisor &&
                    (in_pc >= cfg.text_low) && (in_pc <= cfg.text_high);

  assign q_push   = s1_valid_r && !q_full;
  assign in_stall = sweeping || (s1_valid_r && !q_push);
  assign accept   = in_valid && !in_stall;

  assign bin     = s1_offset_r >> cfg.pc_shift;
  assign idx_ext = 32'(s1_idx_r);
  assign lim_eff = (32'(cfg.bin_limit) < 32'(NUM_BINS)) ? 32'(cfg.bin_limit)
                                                         : 32'(NUM_BINS);

  always_comb begin
    kind = CMD_NOP;
    addr = '0;
    unique case (s1_op_r)
      OP_SAMPLE: begin
        if (s1_in_range_r && (bin < lim_eff)) begin
          kind = CMD_INC;
          addr = bin[ABITS-1:0];
        end
      end
      OP_CLEAR: begin
        kind = CMD_CLEAR;
      end
      OP_READ: begin
        if (idx_ext < lim_eff) begin
          kind = CMD_READ;
          addr = idx_ext[ABITS-1:0];
        end
      end
      default: begin
        kind = CMD_NOP;
      end
    endcase
  end

  assign q_data = {kind, addr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (q_push) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r       <= in_operation;
      s1_in_range_r <= in_range;
      s1_offset_r   <= in_pc - cfg.text_low;
      s1_idx_r      <= in_bin_index;
    end
  end

endmodule

@@ rtl/core/pcsh_back.sv @@
// Back end: owns the bin memory, runs read-modify-write, reads and clearing
// sweeps, and holds the result register. Depends on pcsh_pkg.
module pcsh_back #(
  parameter int unsigned NUM_BINS    = 4096,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       q_valid,
  input  logic [pcsh_pkg::CMD_W+$clog2(NUM_BINS)-1:0] q_data,
  output logic                                       q_pop,
  output logic                                       sweeping,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [COUNT_WIDTH-1:0]                     out_count,
  output logic                                       out_counted
);
  import pcsh_pkg::*;

  localparam int unsigned ABITS = $clog2(NUM_BINS);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  state_t                 state_r;
  logic [ABITS-1:0]       sw_addr_r;
  logic [ABITS-1:0]       acc_addr_r;
  logic                   acc_inc_r;
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic                   out_valid_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic                   out_counted_r;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];

  cmd_kind_t              q_kind;
  logic [ABITS-1:0]       q_addr;
  logic                   out_free;
  logic                   out_load;
  logic                   mem_re;
  logic                   mem_we;
  logic [ABITS-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [COUNT_WIDTH-1:0] bumped;

  assign q_kind   = cmd_kind_t'(q_data[CMD_W+ABITS-1:ABITS]);
  assign q_addr   = q_data[ABITS-1:0];
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && (state_r == ST_IDLE) && out_free;
  assign sweeping = (state_r == ST_SWEEP);

  assign bumped    = rdata_r + COUNT_WIDTH'(1);
  assign mem_re    = q_pop && ((q_kind == CMD_INC) || (q_kind == CMD_READ));
  assign mem_we    = (state_r == ST_SWEEP) || ((state_r == ST_ACCESS) && acc_inc_r);
  assign mem_waddr = (state_r == ST_SWEEP) ? sw_addr_r : acc_addr_r;
  assign mem_wdata = (state_r == ST_SWEEP) ? '0 : bumped;

  // Result register loads this cycle
  assign out_load  = (state_r == ST_ACCESS) || (q_pop && !mem_re);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sw_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_SWEEP: begin
          if (sw_addr_r == ABITS'(NUM_BINS - 1)) begin
            sw_addr_r <= '0;
            state_r   <= ST_IDLE;
          end else begin
            sw_addr_r <= sw_addr_r + ABITS'(1);
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            unique case (q_kind)
              CMD_INC, CMD_READ: begin
                acc_addr_r <= q_addr;
                acc_inc_r  <= (q_kind == CMD_INC);
                state_r    <= ST_ACCESS;
              end
              CMD_CLEAR: begin
                out_valid_r   <= 1'b1;
                out_count_r   <= '0;
                out_counted_r <= 1'b0;
                state_r       <= ST_SWEEP;
              end
              default: begin
                out_valid_r   <= 1'b1;
                out_count_r   <= '0;
                out_counted_r <= 1'b0;
              end
            endcase
          end
        end
        ST_ACCESS: begin
          // Slot was freed when this request was popped
          out_valid_r   <= 1'b1;
          out_count_r   <= acc_inc_r ? bumped : rdata_r;
          out_counted_r <= 1'b1;
          state_r       <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_count   = out_count_r;
  assign out_counted = out_counted_r;

  a_access_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCESS) |-> !out_valid_r)
    else $error("result register busy during bin access");

  a_access_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCESS) |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("bin access did not retire in one cycle");

  a_sweep_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == ST_SWEEP) |-> (sw_addr_r == '0))
    else $error("sweep address not rewound at end of sweep");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !mem_re)
    else $error("memory read issued outside idle state");

endmodule

@@ rtl/core/pc_sample_histogram.sv @@
// Top level of the program-counter sampling histogram: configuration
// registers plus front end, command queue and back end. Depends on pcsh_pkg.
//
// Usage:
//   Input channel (in_*): one request per accepted item, operation 0 takes
//   a sample (in_pc, in_supervisor), 1 clears all bins, 2 reads the bin at
//   in_bin_index. Accepted when in_valid is high and in_stall is low.
//   Result channel (out_*): exactly one result per request, in order,
//   taken when out_valid is high and out_stall is low.
//   Configuration (cfg_*): register index and data, always ready; write
//   only while no request is in flight.
//   A sample or read passes the front stage, the queue and the memory read,
//   then the result register loads along with the write-back. A clear or
//   an unused code loads the result register when it leaves the queue. A
//   sample or read holds the bin memory through its read and write-back, and
//   the back end takes no new request until it has finished. A clear returns
//   its result at once and then sweeps the memory, one bin per cycle.
//   After reset the same sweep runs with in_stall high.
//   A stalled result holds in the output register; the front keeps taking
//   requests until its stage and the two-entry queue are full.
module pc_sample_histogram #(
  parameter int unsigned NUM_BINS    = 4096,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_operation,
  input  logic [31:0]                      in_pc,
  input  logic                             in_supervisor,
  input  logic [11:0]                      in_bin_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COUNT_WIDTH-1:0]           out_count,
  output logic                             out_counted,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcsh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import pcsh_pkg::*;

  localparam int unsigned ABITS = $clog2(NUM_BINS);
  localparam int unsigned QW    = CMD_W + ABITS;

  cfg_t          cfg_r;
  logic          sweeping;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b0;
      cfg_r.text_low  <= '0;
      cfg_r.text_high <= '1;
      cfg_r.pc_shift  <= 5'd2;
      cfg_r.bin_limit <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:    cfg_r.enable    <= cfg_data[0];
        REG_TEXT_LOW:  cfg_r.text_low  <= cfg_data;
        REG_TEXT_HIGH: cfg_r.text_high <= cfg_data;
        REG_PC_SHIFT:  cfg_r.pc_shift  <= cfg_data[4:0];
        REG_BIN_LIMIT: cfg_r.bin_limit <= cfg_data[12:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  pcsh_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .sweeping      (sweeping),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_pc         (in_pc),
    .in_supervisor (in_supervisor),
    .in_bin_index  (in_bin_index),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_full        (q_full)
  );

  pcsh_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_valid)
  );

  pcsh_back #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .sweeping    (sweeping),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_count   (out_count),
    .out_counted (out_counted)
  );

endmodule

@@ tb/sv/pc_sample_histogram_tb.sv @@
// Self-checking testbench for the program-counter sampling histogram.
// Drives sample, clear and read requests against its own histogram predictor
// under several register settings and idle patterns; depends on pcsh_pkg.
`timescale 1ns / 100ps

module pc_sample_histogram_tb;
  import pcsh_pkg::*;

  localparam int unsigned NUM_BINS   = 4096;
  localparam int unsigned BIN_AW     = $clog2(NUM_BINS);
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned SETTLE     = NUM_BINS + 20;
  localparam int unsigned PHASE_REQS = 54;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] pc;
    logic        supervisor;
    logic [11:0] bin_index;
  } hist_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               counted;
  } hist_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_operation = '0;
  logic [31:0]          in_pc = '0;
  logic                 in_supervisor = 1'b0;
  logic [11:0]          in_bin_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_counted;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Predictor state: register copy and bin store
  cfg_t               hist_cfg;
  logic [COUNT_W-1:0] bin_counts [NUM_BINS];

  hist_req_t    pending_requests [$];
  hist_result_t expected_results [$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  logic        in_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned landed_count = 0;
  int unsigned setting_count = 1;

  pc_sample_histogram #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_W)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_pc         (in_pc),
    .in_supervisor (in_supervisor),
    .in_bin_index  (in_bin_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_count     (out_count),
    .out_counted   (out_counted),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned bins_in_use();
    return (hist_cfg.bin_limit < NUM_BINS) ? int'(hist_cfg.bin_limit) : NUM_BINS;
  endfunction

  function automatic hist_result_t predict_bin_update(hist_req_t r);
    hist_result_t res;
    logic [31:0]  bin;
    res = '0;
    case (r.op)
      OP_SAMPLE: begin
        if (hist_cfg.enable && r.supervisor &&
            r.pc >= hist_cfg.text_low && r.pc <= hist_cfg.text_high) begin
          bin = (r.pc - hist_cfg.text_low) >> hist_cfg.pc_shift;
          if (bin < bins_in_use()) begin
            bin_counts[bin[BIN_AW-1:0]] = bin_counts[bin[BIN_AW-1:0]] + COUNT_W'(1);
            res.count = bin_counts[bin[BIN_AW-1:0]];
            res.counted = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        foreach (bin_counts[i]) bin_counts[i] = '0;
      end
      OP_READ: begin
        if (r.bin_index < bins_in_use()) begin
          res.count = bin_counts[r.bin_index];
          res.counted = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly samples aimed at the first few bins, so counts build up and reads
  // find them; the rest is reads, samples at random addresses, clears and the unused code.
  function automatic hist_req_t random_request();
    hist_req_t   r;
    int unsigned pick, span, bin;
    logic [31:0] mask, low_bits;
    r.op = OP_SAMPLE;
    r.pc = $urandom;
    r.supervisor = ($urandom_range(99) < 85);
    r.bin_index = 12'($urandom);
    span = (bins_in_use() == 0) ? 1 : ((bins_in_use() < 12) ? bins_in_use() : 12);
    pick = $urandom_range(99);
    if (pick < 3) begin
      r.op = OP_CLEAR;
    end else if (pick < 5) begin
      r.op = OP_UNUSED;
    end else if (pick < 27) begin
      r.op = OP_READ;
      if ($urandom_range(2) != 0) r.bin_index = 12'($urandom_range(span - 1));
    end else if ($urandom_range(3) != 0) begin
      bin = $urandom_range(span - 1);
      mask = (32'd1 << hist_cfg.pc_shift) - 32'd1;
      low_bits = ($urandom_range(1) != 0) ? $urandom : $urandom_range(3);
      r.pc = hist_cfg.text_low + ((32'(bin) << hist_cfg.pc_shift) | (low_bits & mask));
    end
    return r;
  endfunction

  task automatic push_request(input logic [1:0] op, input logic [31:0] pc,
                              input logic sup, input logic [11:0] idx);
    hist_req_t r;
    r.op = op;
    r.pc = pc;
    r.supervisor = sup;
    r.bin_index = idx;
    pending_requests.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:    hist_cfg.enable = data[0];
      REG_TEXT_LOW:  hist_cfg.text_low = data;
      REG_TEXT_HIGH: hist_cfg.text_high = data;
      REG_PC_SHIFT:  hist_cfg.pc_shift = data[4:0];
      REG_BIN_LIMIT: hist_cfg.bin_limit = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_config(input logic [31:0] en, input logic [31:0] lo,
                              input logic [31:0] hi, input logic [31:0] sh,
                              input logic [31:0] lim);
    write_reg(REG_ENABLE, en);
    write_reg(REG_TEXT_LOW, lo);
    write_reg(REG_TEXT_HIGH, hi);
    write_reg(REG_PC_SHIFT, sh);
    write_reg(REG_BIN_LIMIT, lim);
    setting_count++;
  endtask

  // Wait for every request to be taken and answered, then let a clear sweep finish
  task automatic drain_and_settle();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 81; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 81; end
      default: begin snd_idle_pct = 22; rcv_stall_pct = 22; end
    endcase
  endtask

  // Driver: hold a request until taken, insert idle cycles, randomize stall
  always @(negedge clk) begin
    if (rst_n && (in_taken || !in_valid)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        hist_req_t r;
        r = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_operation <= r.op;
        in_pc <= r.pc;
        in_supervisor <= r.supervisor;
        in_bin_index <= r.bin_index;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    hist_req_t    r;
    hist_result_t exp_res;
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      r.op = in_operation;
      r.pc = in_pc;
      r.supervisor = in_supervisor;
      r.bin_index = in_bin_index;
      exp_res = predict_bin_update(r);
      if (exp_res.counted && r.op == OP_SAMPLE) landed_count++;
      expected_results.push_back(exp_res);
      accepted_count++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("count: no result expected, actual %0d (counted %0d)", out_count, out_counted);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        checked_count++;
        if (out_count !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, out_count);
          mismatch_count++;
        end
        if (out_counted !== exp_res.counted) begin
          $error("counted: expected %0d, actual %0d", exp_res.counted, out_counted);
          mismatch_count++;
        end
      end
    end
    if (cycle_count >= CYCLE_CAP) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned phase, k;
    logic [31:0] lo;
    hist_cfg.enable = 1'b0;
    hist_cfg.text_low = 32'h0000_0000;
    hist_cfg.text_high = 32'hFFFF_FFFF;
    hist_cfg.pc_shift = 5'd2;
    hist_cfg.bin_limit = 13'd4096;
    foreach (bin_counts[i]) bin_counts[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: profiling off, whole store readable
    push_request(OP_SAMPLE, 32'h0000_0100, 1'b1, 12'd0);
    push_request(OP_READ, 32'h0, 1'b0, 12'hFFF);
    drain_and_settle();

    // Range edges, user mode, unused code, clear then recount
    write_config(32'd1, 32'h0000_1000, 32'h0000_1FFF, 32'd2, 32'd4096);
    push_request(OP_SAMPLE, 32'h0000_1000, 1'b1, 12'd0);
    push_request(OP_SAMPLE, 32'h0000_1003, 1'b1, 12'd0);
    push_request(OP_SAMPLE, 32'h0000_1FFF, 1'b1, 12'd0);
    push_request(OP_SAMPLE, 32'h0000_0FFF, 1'b1, 12'd0);
    push_request(OP_SAMPLE, 32'h0000_2000, 1'b1, 12'd0);
    push_request(OP_SAMPLE, 32'h0000_1004, 1'b0, 12'd0);
    push_request(OP_READ, 32'h0, 1'b0, 12'd0);
    push_request(OP_READ, 32'h0, 1'b0, 12'd1023);
    push_request(OP_READ, 32'h0, 1'b0, 12'hFFF);
    push_request(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 12'hFFF);
    push_request(OP_CLEAR, 32'h0, 1'b1, 12'd0);
    push_request(OP_READ, 32'h0, 1'b0, 12'd0);
    push_request(OP_SAMPLE, 32'h0000_1000, 1'b1, 12'd0);
    drain_and_settle();

    // Full address space in two bins; upper data bits must be dropped
    write_config(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F001);
    push_request(OP_SAMPLE, 32'h0000_0000, 1'b1, 12'd0);
    push_request(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 12'd0);
    push_request(OP_SAMPLE, 32'h7FFF_FFFF, 1'b1, 12'd0);
    push_request(OP_SAMPLE, 32'h8000_0000, 1'b1, 12'd0);
    push_request(OP_READ, 32'h0, 1'b0, 12'd0);
    push_request(OP_READ, 32'h0, 1'b0, 12'd1);
    push_request(OP_READ, 32'h0, 1'b0, 12'hFFF);
    drain_and_settle();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_config(32'd1, 32'h0, 32'hFFFF_FFFF, 32'd0, 32'd8191);
        1: write_config(32'd1, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'd0, 32'd4096);
        // inverted range: nothing may count
        2: write_config(32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3, 32'd100);
        3: write_config(32'd1, $urandom, $urandom, $urandom, $urandom & 32'hFFFF_E000);
        4: write_config(32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFF, 32'd2, 32'd4096);
        5: write_config(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd31, 32'd1);
        6: write_config(32'd1, 32'h0, 32'h0, 32'd5, 32'd7);
        default: begin
          lo = $urandom;
          write_config(32'd1, lo, lo + $urandom_range(32'h0010_0000), $urandom_range(6),
                       $urandom_range(64, 1));
        end
      endcase
      set_idle(phase % 4);
      for (k = 0; k < PHASE_REQS; k++) pending_requests.push_back(random_request());
      drain_and_settle();
      set_idle(0);
    end

    repeat (20) @(posedge clk);
    $display("Checked %0d results for %0d requests under %0d register settings;",
             checked_count, accepted_count, setting_count);
    $display("%0d samples landed in a bin, the rest were dropped, reads, clears or unused.",
             landed_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/pcsh_pkg.sv
rtl/core/pcsh_queue.sv
rtl/core/pcsh_front.sv
rtl/core/pcsh_back.sv
rtl/core/pc_sample_histogram.sv
tb/sv/pc_sample_histogram_tb.sv
